@@ sv/sle_pkg.sv @@
// shared types and constants for the sync/length frame value extractor
// no dependencies; imported by every module of the block
package sle_pkg;

    localparam int BYTE_W    = 8;
    localparam int VALUE_W   = 64;
    localparam int VALUE_BYTES = VALUE_W / BYTE_W;
    localparam int CFG_IDX_W = 1;
    localparam int PHASE_W   = 3;

    localparam logic [BYTE_W-1:0] SYNC_FIRST = 8'hFF;
    localparam logic [BYTE_W-1:0] RESET_DEVICE_ID = 8'h01;
    localparam logic [BYTE_W-1:0] RESET_VALUE_COMMAND = 8'h01;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DEVICE_ID     = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_VALUE_COMMAND = 1'b1;

    // parser phases
    localparam logic [PHASE_W-1:0] PH_HUNT0   = 3'd0;
    localparam logic [PHASE_W-1:0] PH_HUNT1   = 3'd1;
    localparam logic [PHASE_W-1:0] PH_CMD     = 3'd2;
    localparam logic [PHASE_W-1:0] PH_LEN     = 3'd3;
    localparam logic [PHASE_W-1:0] PH_PAYLOAD = 3'd4;

    typedef struct packed {
        logic               valid;
        logic [VALUE_W-1:0] value_bits;
    } t_sle_result;

endpackage

@@ sv/sync_length_frame_value_extractor.sv @@
// top level of the sync/length frame value extractor
// depends on sle_pkg, sle_frame_parser, sle_out_buf

// Takes one received byte per cycle, sustained, and hunts for the sync pair 0xFF, device_id,
// then a command byte, a length byte and that many payload bytes; payload is never searched
// for sync. When a frame whose command equals value_command and whose length is at least
// eight ends, the first eight payload bytes (least significant first) come out as one 64-bit
// word; shorter value frames and all other frames give nothing. Each byte is registered on
// acceptance and parsed from the input register, and a result word is then registered in the output
// register, or in its skid entry while the output is stalled. The input
// stalls only when both the output register and its skid entry hold words. Configuration
// writes take effect on the next byte parsed and should be made while the block is idle.
module sync_length_frame_value_extractor import sle_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [BYTE_W-1:0]    i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [BYTE_W-1:0]    i_rx_byte,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [VALUE_W-1:0]   o_value_bits
);

    t_sle_result w_result;
    logic        w_buf_ready;

    sle_frame_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_rx_byte   (i_rx_byte),
        .i_ready     (w_buf_ready),
        .o_result    (w_result)
    );

    sle_out_buf u_out_buf (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_result     (w_result),
        .o_ready      (w_buf_ready),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_value_bits (o_value_bits)
    );

`ifndef SYNTHESIS
    a_result_only_when_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_result.valid |-> w_buf_ready)
        else $error("result word issued while output buffer full");

    a_skid_implies_out_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_buf_ready |-> o_out_valid)
        else $error("skid entry full with empty output register");

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> !w_buf_ready)
        else $error("input stalled while output buffer has room");
`endif

endmodule

@@ sv/sle_frame_parser.sv @@
// input word register, frame state machine and value assembly
// depends on sle_pkg
module sle_frame_parser import sle_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [BYTE_W-1:0]    i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [BYTE_W-1:0]    i_rx_byte,
    input  logic                 i_ready,
    output t_sle_result          o_result
);

    logic                r_in_valid;
    logic [BYTE_W-1:0]   r_in_byte;
    logic [BYTE_W-1:0]   r_device_id;
    logic [BYTE_W-1:0]   r_value_command;
    logic [PHASE_W-1:0]  r_phase;
    logic [BYTE_W-1:0]   r_frame_command;
    logic [BYTE_W-1:0]   r_frame_length;
    logic [BYTE_W-1:0]   r_payload_count;
    logic [VALUE_W-1:0]  r_value_shift;

    logic [PHASE_W-1:0]  n_phase;
    logic [BYTE_W-1:0]   n_frame_command;
    logic [BYTE_W-1:0]   n_frame_length;
    logic [BYTE_W-1:0]   n_payload_count;
    logic [VALUE_W-1:0]  n_value_shift;
    logic [VALUE_W-1:0]  w_merged;
    logic                w_fire;
    logic                w_load;
    logic                w_emit;

    assign w_fire     = r_in_valid && i_ready;
    assign o_in_stall = r_in_valid && !i_ready;
    assign w_load     = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_load) begin
            r_in_valid <= 1'b1;
        end else if (w_fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_in_byte <= i_rx_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_device_id     <= RESET_DEVICE_ID;
            r_value_command <= RESET_VALUE_COMMAND;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_DEVICE_ID:     r_device_id     <= i_cfg_data;
                CFG_VALUE_COMMAND: r_value_command <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // current payload word dropped into its byte lane, first eight only
    always_comb begin
        w_merged = r_value_shift;
        for (int k = 0; k < VALUE_BYTES; k++) begin
            if (r_payload_count == BYTE_W'(k)) begin
                w_merged[k*BYTE_W +: BYTE_W] = r_value_shift[k*BYTE_W +: BYTE_W] | r_in_byte;
            end
        end
    end

    always_comb begin
        n_phase         = r_phase;
        n_frame_command = r_frame_command;
        n_frame_length  = r_frame_length;
        n_payload_count = r_payload_count;
        n_value_shift   = r_value_shift;
        w_emit          = 1'b0;
        case (r_phase)
            PH_HUNT1: begin
                if (r_in_byte == r_device_id) begin
                    n_phase = PH_CMD;
                end else if (r_in_byte == SYNC_FIRST) begin
                    n_phase = PH_HUNT1;
                end else begin
                    n_phase = PH_HUNT0;
                end
            end
            PH_CMD: begin
                n_frame_command = r_in_byte;
                n_phase         = PH_LEN;
            end
            PH_LEN: begin
                n_frame_length  = r_in_byte;
                n_payload_count = '0;
                n_value_shift   = '0;
                n_phase         = (r_in_byte == '0) ? PH_HUNT0 : PH_PAYLOAD;
            end
            PH_PAYLOAD: begin
                n_value_shift   = w_merged;
                n_payload_count = r_payload_count + BYTE_W'(1);
                if (n_payload_count >= r_frame_length) begin
                    // short value frames are dropped
                    w_emit  = (r_frame_command == r_value_command) &&
                              (r_frame_length >= BYTE_W'(VALUE_BYTES));
                    n_phase = PH_HUNT0;
                end
            end
            default: begin
                n_phase = (r_in_byte == SYNC_FIRST) ? PH_HUNT1 : PH_HUNT0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase         <= PH_HUNT0;
            r_frame_command <= '0;
            r_frame_length  <= '0;
            r_payload_count <= '0;
            r_value_shift   <= '0;
        end else if (w_fire) begin
            r_phase         <= n_phase;
            r_frame_command <= n_frame_command;
            r_frame_length  <= n_frame_length;
            r_payload_count <= n_payload_count;
            r_value_shift   <= n_value_shift;
        end
    end

    assign o_result.valid      = w_fire && w_emit;
    assign o_result.value_bits = w_merged;

endmodule

@@ sv/sle_out_buf.sv @@
// result register with a skid entry, so the parser never waits on a combinational stall
// depends on sle_pkg
module sle_out_buf import sle_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_sle_result        i_result,
    output logic               o_ready,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [VALUE_W-1:0] o_value_bits
);

    logic               r_out_valid;
    logic [VALUE_W-1:0] r_out_bits;
    logic               r_skid_valid;
    logic [VALUE_W-1:0] r_skid_bits;
    logic               w_out_free;

    assign o_ready      = !r_skid_valid;
    assign w_out_free   = !r_out_valid || !i_out_stall;
    assign o_out_valid  = r_out_valid;
    assign o_value_bits = r_out_bits;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (w_out_free) begin
            // skid entry drains first; no new word can arrive while it is full
            r_out_valid  <= r_skid_valid || i_result.valid;
            r_skid_valid <= 1'b0;
        end else if (i_result.valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_free) begin
            r_out_bits <= r_skid_valid ? r_skid_bits : i_result.value_bits;
        end
        if (!w_out_free && i_result.valid) begin
            r_skid_bits <= i_result.value_bits;
        end
    end

endmodule

@@ bench/sle_value_checker.sv @@
// watches both channels and the register port of the frame value extractor,
// predicts the 64-bit words it should emit and compares them in order
// depends on sle_pkg
module sle_value_checker import sle_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [BYTE_W-1:0]    i_cfg_data,
    input  logic                 i_in_valid,
    input  logic                 i_in_stall,
    input  logic [BYTE_W-1:0]    i_rx_byte,
    input  logic                 i_out_valid,
    input  logic                 i_out_stall,
    input  logic [VALUE_W-1:0]   i_value_bits,
    output int                   o_fail_count,
    output int                   o_values_pending
);

    logic [BYTE_W-1:0]  dev_id;
    logic [BYTE_W-1:0]  val_cmd;
    logic [PHASE_W-1:0] phase;
    logic [BYTE_W-1:0]  frm_cmd;
    logic [BYTE_W-1:0]  frm_len;
    logic [BYTE_W-1:0]  pay_cnt;
    logic [VALUE_W-1:0] gathered;
    logic [VALUE_W-1:0] expected_values[$];
    logic [VALUE_W-1:0] want;
    int                 fails = 0;

    initial begin
        o_fail_count     = 0;
        o_values_pending = 0;
    end

    // advance the frame parser by one received byte
    task automatic parse_byte(input logic [BYTE_W-1:0] b);
        case (phase)
            PH_HUNT1: begin
                if (b == dev_id)
                    phase = PH_CMD;
                else if (b == SYNC_FIRST)
                    phase = PH_HUNT1;
                else
                    phase = PH_HUNT0;
            end
            PH_CMD: begin
                frm_cmd = b;
                phase   = PH_LEN;
            end
            PH_LEN: begin
                frm_len  = b;
                pay_cnt  = '0;
                gathered = '0;
                phase    = (b == '0) ? PH_HUNT0 : PH_PAYLOAD;
            end
            PH_PAYLOAD: begin
                if (pay_cnt < VALUE_BYTES)
                    gathered[BYTE_W*pay_cnt +: BYTE_W] = b;
                pay_cnt = pay_cnt + 1'b1;
                if (pay_cnt >= frm_len) begin
                    // short value frames end silently
                    if (frm_cmd == val_cmd && frm_len >= VALUE_BYTES)
                        expected_values.insert(expected_values.size(), gathered);
                    phase = PH_HUNT0;
                end
            end
            default: begin
                phase = (b == SYNC_FIRST) ? PH_HUNT1 : PH_HUNT0;
            end
        endcase
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            dev_id   = RESET_DEVICE_ID;
            val_cmd  = RESET_VALUE_COMMAND;
            phase    = PH_HUNT0;
            frm_cmd  = '0;
            frm_len  = '0;
            pay_cnt  = '0;
            gathered = '0;
            expected_values.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (expected_values.size() == 0) begin
                    fails++;
                    $display("%0t: unexpected word, expected none, actual %h", $time,
                             i_value_bits);
                end else begin
                    want = expected_values.pop_front();
                    if (want !== i_value_bits) begin
                        fails++;
                        $display("%0t: value_bits mismatch, expected %h, actual %h", $time,
                                 want, i_value_bits);
                    end
                end
            end
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_DEVICE_ID)
                    dev_id = i_cfg_data;
                else if (i_cfg_index == CFG_VALUE_COMMAND)
                    val_cmd = i_cfg_data;
            end
            if (i_in_valid && !i_in_stall)
                parse_byte(i_rx_byte);
        end
        o_fail_count     <= fails;
        o_values_pending <= expected_values.size();
    end

endmodule

@@ bench/sync_length_frame_value_extractor_tb.sv @@
// stimulus and verdict for the sync/length frame value extractor
// depends on sle_pkg, sync_length_frame_value_extractor and sle_value_checker
module sync_length_frame_value_extractor_tb;
    import sle_pkg::*;

    typedef enum int {FK_VALUE, FK_SHORT, FK_OTHER, FK_JUNK, FK_BROKEN} t_frame_kind;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [BYTE_W-1:0]    i_cfg_data;
    logic                 i_in_valid;
    logic                 o_in_stall;
    logic [BYTE_W-1:0]    i_rx_byte;
    logic                 o_out_valid;
    logic                 i_out_stall;
    logic [VALUE_W-1:0]   o_value_bits;

    int fail_count;
    int values_pending;

    logic [BYTE_W-1:0] dev_now = RESET_DEVICE_ID;
    logic [BYTE_W-1:0] cmd_now = RESET_VALUE_COMMAND;
    int send_pct  = 17;
    int recv_pct  = 59;
    int hold_left = 0;
    int bytes_sent = 0;

    sync_length_frame_value_extractor DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_rx_byte    (i_rx_byte),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_value_bits (o_value_bits)
    );

    sle_value_checker value_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .i_in_stall       (o_in_stall),
        .i_rx_byte        (i_rx_byte),
        .i_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .i_value_bits     (o_value_bits),
        .o_fail_count     (fail_count),
        .o_values_pending (values_pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // receiver side: random stall, or a long hold-off when one is requested
    initial begin
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                i_out_stall <= 1'b1;
                hold_left--;
            end else begin
                i_out_stall <= ($urandom_range(99) < recv_pct);
            end
        end
    end

    // returns at the rising edge where the word was taken
    task automatic send_byte(input logic [BYTE_W-1:0] b);
        @(negedge i_clk);
        while ($urandom_range(99) < send_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_rx_byte  <= b;
        do @(posedge i_clk); while (o_in_stall);
        bytes_sent++;
    endtask

    function automatic logic [BYTE_W-1:0] pick_byte();
        case ($urandom_range(7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return BYTE_W'($urandom_range(255));
        endcase
    endfunction

    task automatic send_frame(input logic [BYTE_W-1:0] cmd, input int len);
        send_byte(SYNC_FIRST);
        send_byte(dev_now);
        send_byte(cmd);
        send_byte(BYTE_W'(len));
        for (int i = 0; i < len; i++)
            send_byte(pick_byte());
    endtask

    // sender goes quiet until every word has come out and the pipe is empty
    task automatic drain();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (values_pending != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // called only while idle, right after drain
    task automatic write_regs(input logic [BYTE_W-1:0] dev, input logic [BYTE_W-1:0] cmd);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_DEVICE_ID;
        i_cfg_data  <= dev;
        @(negedge i_clk);
        i_cfg_index <= CFG_VALUE_COMMAND;
        i_cfg_data  <= cmd;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        dev_now = dev;
        cmd_now = cmd;
    endtask

    task automatic send_random(input int stop_at);
        t_frame_kind       kind;
        int                r;
        int                len;
        logic [BYTE_W-1:0] b;
        while (bytes_sent < stop_at) begin
            r = $urandom_range(99);
            if (r < 55)      kind = FK_VALUE;
            else if (r < 65) kind = FK_SHORT;
            else if (r < 80) kind = FK_OTHER;
            else if (r < 90) kind = FK_JUNK;
            else             kind = FK_BROKEN;
            case (kind)
                FK_VALUE: begin
                    len = ($urandom_range(39) == 0) ? $urandom_range(255, 13)
                                                    : $urandom_range(12, VALUE_BYTES);
                    send_frame(cmd_now, len);
                end
                FK_SHORT: begin
                    send_frame(cmd_now, $urandom_range(VALUE_BYTES - 1));
                end
                FK_OTHER: begin
                    b = BYTE_W'($urandom_range(255));
                    if (b == cmd_now)
                        b = ~b;
                    send_frame(b, $urandom_range(12));
                end
                FK_JUNK: begin
                    repeat ($urandom_range(3, 1))
                        send_byte(pick_byte());
                end
                default: begin
                    // sync start followed by a byte that cannot finish it
                    send_byte(SYNC_FIRST);
                    do b = BYTE_W'($urandom_range(255));
                    while (b == dev_now || b == SYNC_FIRST);
                    send_byte(b);
                end
            endcase
        end
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_index = CFG_DEVICE_ID;
        i_cfg_data  = '0;
        i_in_valid  = 1'b0;
        i_rx_byte   = '0;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // repeated sync start, full value frame with extreme payload bytes
        send_byte(SYNC_FIRST);
        send_byte(SYNC_FIRST);
        send_byte(dev_now);
        send_byte(cmd_now);
        send_byte(BYTE_W'(VALUE_BYTES));
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h01);
        send_byte(8'h80);
        send_byte(8'hFE);
        send_byte(8'h7F);
        send_byte(8'hAA);
        send_byte(8'h55);
        // zero length, then value frame one byte short
        send_frame(cmd_now, 0);
        send_frame(cmd_now, VALUE_BYTES - 1);
        drain();

        for (int p = 0; p < 4; p++) begin
            case (p)
                0: begin
                    write_regs(8'h01, 8'h01);
                    send_pct = 17;
                    recv_pct = 59;
                end
                1: begin
                    write_regs(8'hFF, 8'h00);
                    send_pct = 59;
                    recv_pct = 17;
                end
                2: begin
                    write_regs(8'h00, 8'hFF);
                    send_pct = 0;
                    recv_pct = 0;
                end
                default: begin
                    write_regs(BYTE_W'($urandom_range(255)), BYTE_W'($urandom_range(255)));
                    send_pct = 0;
                    recv_pct = 0;
                end
            endcase
            if (p == 0) begin
                // long receiver hold-off so the output side backs up into the input
                hold_left = 300;
                repeat (20)
                    send_frame(cmd_now, VALUE_BYTES);
                drain();
            end
            send_random(bytes_sent + 370);
            drain();
        end

        repeat (10) @(posedge i_clk);
        if (fail_count == 0 && values_pending == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
